/* hw/rtl/lkvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache: word widths,
// operation codes, one stored entry and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int KEY_W       = 32;
	localparam int DATA_W      = 32;
	localparam int ENTRIES_DEF = 8;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} entry_t;

	// promote: hit entry to the head, cells in front of it move back one
	// push:    every cell moves back one, new entry at the head
	// pull:    hit cell and all behind it move forward one
	typedef struct packed {
		logic promote;
		logic push;
		logic pull;
	} cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/lru_key_value_cache.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement,
// built as a chain of cells kept in recency order (head = most recent).
//
//   channel   signals                       handshake
//   request   kind, key, value              start (busy is always low)
//   result    found, read_value             done, one cycle, no stall
//
// One request per clock: compare, hit select and chain shift finish in the
// accepting cycle, so the next request sees the updated store.
// The result is registered and shows on done in the cycle after acceptance.
// Reset empties the store at once; no clearing pass.
// The receiver cannot stall; busy stays low.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
	input  logic signed [lkvc_pkg::DATA_W-1:0] value,
	output logic                               done,
	output logic                               found,
	output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);
	import lkvc_pkg::*;

	logic              seen  [0:ENTRIES];
	logic [DATA_W-1:0] rdata [0:ENTRIES];
	entry_t            ent_x [0:ENTRIES+1];
	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] valid_vec;

	logic              accept;
	logic              hit;
	logic [DATA_W-1:0] hit_data;
	cmd_t              cmd;
	logic              found_d;
	logic [DATA_W-1:0] rd_d;

	logic              done_q;
	logic              found_q;
	logic [DATA_W-1:0] read_value_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign seen[0]  = 1'b0;
	assign rdata[0] = '0;
	assign hit      = seen[ENTRIES];
	assign hit_data = rdata[ENTRIES];

	// head input: hit entry on promote, new word on push
	assign ent_x[0]         = '{valid: 1'b1, key: key,
	                            data: (hit ? hit_data : value)};
	assign ent_x[ENTRIES+1] = '{valid: 1'b0, key: '0, data: '0};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.req_key     (key),
			.seen_ahead  (seen[i]),
			.rdata_ahead (rdata[i]),
			.prev_entry  (ent_x[i]),
			.next_entry  (ent_x[i+2]),
			.seen_here   (seen[i+1]),
			.rdata_here  (rdata[i+1]),
			.match       (match_vec[i]),
			.entry       (ent_x[i+1])
		);
		assign valid_vec[i] = ent_x[i+1].valid;
	end

	always_comb begin
		cmd     = '0;
		found_d = 1'b0;
		rd_d    = '0;
		if (accept) begin
			unique case (kind)
				KIND_LOOKUP: begin
					cmd.promote = hit;
					found_d     = hit;
					rd_d        = hit ? hit_data : '0;
				end
				KIND_INSERT: begin
					cmd.promote = hit;
					cmd.push    = !hit;
					found_d     = hit;
				end
				KIND_REMOVE: begin
					cmd.pull = hit;
					found_d  = hit;
				end
				default: begin
					cmd = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		found_q      <= found_d;
		read_value_q <= rd_d;
	end

	assign done       = done_q;
	assign found      = found_q;
	assign read_value = read_value_q;

`ifndef SYNTHESIS
	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("key stored in more than one cell");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("gap in the recency chain");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted word gave no result");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pull |=> $countones(valid_vec) == $past($countones(valid_vec)) - 1)
		else $error("remove did not free exactly one entry");

	a_data_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (read_value != '0)) |-> found)
		else $error("read data without a hit");
`endif

endmodule
`default_nettype wire

/* hw/rtl/lkvc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell
// One place of the recency chain. Holds one entry, compares it against the
// request key and takes its next contents from itself or either neighbour.
// ----------------------------------------------------------------------------
module lkvc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkvc_pkg::cmd_t              cmd,
	input  logic [lkvc_pkg::KEY_W-1:0]  req_key,
	input  logic                        seen_ahead,
	input  logic [lkvc_pkg::DATA_W-1:0] rdata_ahead,
	input  lkvc_pkg::entry_t            prev_entry,
	input  lkvc_pkg::entry_t            next_entry,
	output logic                        seen_here,
	output logic [lkvc_pkg::DATA_W-1:0] rdata_here,
	output logic                        match,
	output lkvc_pkg::entry_t            entry
);
	import lkvc_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic              take_prev;
	logic              take_next;
	entry_t            nxt;

	assign match      = valid_q && (key_q == req_key);
	assign seen_here  = seen_ahead | match;
	assign rdata_here = rdata_ahead | (match ? data_q : '0);

	assign take_prev = (cmd.promote && !seen_ahead) || cmd.push;
	assign take_next = cmd.pull && seen_here;

	always_comb begin
		priority if (take_prev) begin
			nxt = prev_entry;
		end else if (take_next) begin
			nxt = next_entry;
		end else begin
			nxt = entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= nxt.key;
		data_q <= nxt.data;
	end

	assign entry = '{valid: valid_q, key: key_q, data: data_q};

endmodule
`default_nettype wire

/* tb/lru_key_value_cache_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches the request and result channels of the LRU key-value cache. It keeps
// its own copy of the store (keys, data, valid marks and recency ranks) and
// works out the result of every accepted request word. Each result word is
// compared with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [1:0]                          kind,
	input  logic signed [lkvc_pkg::KEY_W-1:0]   key,
	input  logic signed [lkvc_pkg::DATA_W-1:0]  value,
	input  logic                                done,
	input  logic                                found,
	input  logic signed [lkvc_pkg::DATA_W-1:0]  read_value,
	output int                                  fails,
	output int                                  pending
);
	import lkvc_pkg::*;

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct {
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
	} outcome_t;

	logic [KEY_W-1:0]  slot_key   [ENTRIES];
	logic [DATA_W-1:0] slot_data  [ENTRIES];
	logic              slot_valid [ENTRIES];
	logic [RANK_W-1:0] slot_rank  [ENTRIES];

	outcome_t outcome_q [$];
	outcome_t want;
	int       err_count = 0;
	int       pending_n = 0;

	assign fails   = err_count;
	assign pending = pending_n;

	// move entry s to the head, entries more recent than it age by one
	function automatic void promote(input int s);
		logic [RANK_W-1:0] r;
		r = slot_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_rank[i] < r)
				slot_rank[i] = slot_rank[i] + 1'b1;
		slot_rank[s] = '0;
	endfunction

	function automatic outcome_t predict_access(input logic [1:0] op,
			input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] v);
		outcome_t          res;
		int                hit;
		int                slot;
		logic [RANK_W-1:0] r;
		res.found      = 1'b0;
		res.read_value = '0;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && slot_valid[i] && slot_key[i] == k)
				hit = i;
		case (op)
			KIND_LOOKUP: begin
				if (hit >= 0) begin
					res.found      = 1'b1;
					res.read_value = slot_data[hit];
					promote(hit);
				end
			end
			KIND_INSERT: begin
				if (hit >= 0) begin
					res.found = 1'b1;
					promote(hit);
				end else begin
					slot = -1;
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !slot_valid[i])
							slot = i;
					// store full: drop the least recent entry
					if (slot < 0) begin
						slot = 0;
						for (int i = 0; i < ENTRIES; i++)
							if (slot_rank[i] >= slot_rank[slot])
								slot = i;
						slot_valid[slot] = 1'b0;
					end
					for (int i = 0; i < ENTRIES; i++)
						if (slot_valid[i])
							slot_rank[i] = slot_rank[i] + 1'b1;
					slot_key[slot]   = k;
					slot_data[slot]  = v;
					slot_valid[slot] = 1'b1;
					slot_rank[slot]  = '0;
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					res.found = 1'b1;
					r = slot_rank[hit];
					slot_valid[hit] = 1'b0;
					slot_rank[hit]  = '0;
					for (int i = 0; i < ENTRIES; i++)
						if (slot_valid[i] && slot_rank[i] > r)
							slot_rank[i] = slot_rank[i] - 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_valid[i] = 1'b0;
				slot_rank[i]  = '0;
			end
			outcome_q.delete();
			pending_n = 0;
		end else begin
			// result word of an earlier request goes first
			if (done) begin
				if (outcome_q.size() == 0) begin
					$display("%0t unexpected result word: found %0b read_value %0d",
						$time, found, read_value);
					err_count++;
				end else begin
					want = outcome_q.pop_front();
					if (found !== want.found) begin
						$display("%0t found mismatch: expected %0b actual %0b",
							$time, want.found, found);
						err_count++;
					end
					if (read_value !== want.read_value) begin
						$display("%0t read_value mismatch: expected %0d actual %0d",
							$time, want.read_value, read_value);
						err_count++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(predict_access(kind, key, value));
			pending_n = outcome_q.size();
		end
	end

endmodule

/* tb/lru_key_value_cache_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test
// Drives lookup, insert, remove and unused request words into the LRU
// key-value cache: a directed run over the extremes, eviction and freeing,
// then random words drawn mostly from a small key pool so that hits,
// evictions and removes are frequent. Random gaps and gap-free bursts sit
// between words; the checker beside the block judges every result word.
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;
	import lkvc_pkg::*;

	localparam int         RANDOM_WORDS   = 650;
	localparam int         POOL_SIZE      = 12;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         DRAIN_CYCLES   = 4;
	localparam logic [1:0] KIND_UNUSED    = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               kind;
	logic signed [KEY_W-1:0]  key;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic                     found;
	logic signed [DATA_W-1:0] read_value;
	int                       fails;
	int                       pending;

	int                       idle_cycles;
	int                       burst_left;
	logic [KEY_W-1:0]         key_pool [POOL_SIZE];

	lru_key_value_cache dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.key        (key),
		.value      (value),
		.done       (done),
		.found      (found),
		.read_value (read_value)
	);

	lru_key_value_cache_checker check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.key        (key),
		.value      (value),
		.done       (done),
		.found      (found),
		.read_value (read_value),
		.fails      (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones, and gap-free bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 8) begin
			burst_left = $urandom_range(40, 10);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// called just after a rising edge; returns at the edge that takes the word
	task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= op;
		key   <= k;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int               r;
		logic [1:0]       op;
		logic [KEY_W-1:0] k;
		arst_n      = 1'b0;
		start       = 1'b0;
		kind        = KIND_LOOKUP;
		key         = '0;
		value       = '0;
		idle_cycles = 0;
		burst_left  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, refresh, eviction, freeing
		send_word(KIND_LOOKUP, 32'h0000_0000, 32'h1111_1111);
		send_word(KIND_REMOVE, 32'h7fff_ffff, 32'h0000_0000);
		send_word(KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		send_word(KIND_INSERT, 32'h7fff_ffff, 32'h8000_0000);
		send_word(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
		send_word(KIND_INSERT, 32'hffff_ffff, 32'hffff_ffff);
		send_word(KIND_INSERT, 32'h8000_0000, 32'h1234_5678);
		send_word(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		send_word(KIND_INSERT, 32'h0000_0001, 32'h5555_5555);
		send_word(KIND_INSERT, 32'haaaa_aaaa, 32'haaaa_aaaa);
		send_word(KIND_INSERT, 32'h5555_5555, 32'h5555_5555);
		send_word(KIND_INSERT, 32'h0000_0002, 32'h0000_0002);
		send_word(KIND_INSERT, 32'h0000_0003, 32'hdead_beef);
		send_word(KIND_LOOKUP, 32'h7fff_ffff, 32'h0000_0000);
		send_word(KIND_REMOVE, 32'h0000_0000, 32'h0000_0000);
		send_word(KIND_INSERT, 32'h0000_0004, 32'hcafe_f00d);
		send_word(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
		send_word(KIND_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
		send_word(KIND_REMOVE, 32'hffff_ffff, 32'h0000_0000);
		send_word(KIND_REMOVE, 32'hffff_ffff, 32'h0000_0000);
		send_word(KIND_INSERT, 32'h0000_0005, 32'h8000_0001);
		send_word(KIND_INSERT, 32'h0000_0006, 32'h7fff_fffe);
		send_word(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);

		// small pool of keys keeps hits and evictions frequent
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(9) == 0)
				key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
			r = $urandom_range(99);
			if (r < 40)
				op = KIND_LOOKUP;
			else if (r < 75)
				op = KIND_INSERT;
			else if (r < 95)
				op = KIND_REMOVE;
			else
				op = KIND_UNUSED;
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = $urandom;
			send_word(op, k, $urandom);
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
